// ===== hw/rtl/vec_pkg.sv =====
package vec_pkg;

	localparam int DEFAULT_MAX_DIM = 256;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;

	localparam int EULER_W  = 28;
	localparam int VERTEX_W = 25;
	localparam int EDGE_W   = 26;
	localparam int FACE_W   = 26;
	localparam int CUBE_W   = 25;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// Per-voxel flags carried from the scan position into the counting stage.
	typedef struct packed {
		logic voxel;
		logic last_x;
		logic last_y;
		logic last_z;
		logic x_nz;
		logic y_nz;
		logic z_nz;
	} item_flags_t;

	// Neighbor voxels: up is (x,y-1,z), back is (x,y,z-1), diag is (x,y-1,z-1).
	typedef struct packed {
		logic up;
		logic back;
		logic diag;
	} nbr_t;

	typedef struct packed {
		logic [EULER_W-1:0]  euler;
		logic [VERTEX_W-1:0] vertex;
		logic [EDGE_W-1:0]   edges;
		logic [FACE_W-1:0]   face;
		logic [CUBE_W-1:0]   cube;
	} totals_t;

	// Window bit (dx,dy,dz) sits at dx*4+dy*2+dz; offset 1 is the current coordinate.
	// A mask bit selects which offsets along that axis take part.
	function automatic logic touch(input logic [7:0] w, input logic [1:0] mx,
			input logic [1:0] my, input logic [1:0] mz);
		logic hit;
		hit = 1'b0;
		for (int dx = 0; dx < 2; dx++) begin
			for (int dy = 0; dy < 2; dy++) begin
				for (int dz = 0; dz < 2; dz++) begin
					if (mx[dx] && my[dy] && mz[dz] && w[dx*4 + dy*2 + dz]) begin
						hit = 1'b1;
					end
				end
			end
		end
		return hit;
	endfunction

	function automatic logic [1:0] axis_mask(input logic far_side);
		return far_side ? 2'b10 : 2'b11;
	endfunction

	// Vertices closed by this voxel; far-side vertices only at the end of an axis.
	function automatic logic [3:0] vertex_inc(input logic [7:0] w, input logic lx,
			input logic ly, input logic lz);
		logic [3:0] cnt;
		cnt = 4'd0;
		for (int a = 0; a < 2; a++) begin
			for (int b = 0; b < 2; b++) begin
				for (int c = 0; c < 2; c++) begin
					if ((a == 0 || lx) && (b == 0 || ly) && (c == 0 || lz)) begin
						cnt = cnt + {3'd0, touch(w, axis_mask(a == 1), axis_mask(b == 1),
							axis_mask(c == 1))};
					end
				end
			end
		end
		return cnt;
	endfunction

	// Edges closed by this voxel, one group per edge direction.
	function automatic logic [3:0] edge_inc(input logic [7:0] w, input logic lx,
			input logic ly, input logic lz);
		logic [3:0] cnt;
		cnt = 4'd0;
		for (int p = 0; p < 2; p++) begin
			for (int q = 0; q < 2; q++) begin
				if ((p == 0 || ly) && (q == 0 || lz)) begin
					cnt = cnt + {3'd0, touch(w, 2'b10, axis_mask(p == 1), axis_mask(q == 1))};
				end
				if ((p == 0 || lx) && (q == 0 || lz)) begin
					cnt = cnt + {3'd0, touch(w, axis_mask(p == 1), 2'b10, axis_mask(q == 1))};
				end
				if ((p == 0 || lx) && (q == 0 || ly)) begin
					cnt = cnt + {3'd0, touch(w, axis_mask(p == 1), axis_mask(q == 1), 2'b10)};
				end
			end
		end
		return cnt;
	endfunction

endpackage

// ===== hw/rtl/vec_history.sv =====
module vec_history import vec_pkg::*; #(
	parameter int MAX_DIM = DEFAULT_MAX_DIM,
	localparam int ROW_AW = $clog2(MAX_DIM),
	localparam int PLANE_AW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [ROW_AW-1:0]   rd_row_addr,
	input  logic [PLANE_AW-1:0] rd_plane_addr,
	input  logic                wr_en,
	input  logic [ROW_AW-1:0]   wr_row_addr,
	input  logic [PLANE_AW-1:0] wr_plane_addr,
	input  logic                wr_voxel,
	input  logic                wr_back,
	output nbr_t                nbr_raw
);

	localparam int PLANE_DEPTH = MAX_DIM * MAX_DIM;

	// Plane memory holds the previous plane; row memory holds the previous row
	// as {voxel, its back neighbor}, so one read gives both up and diag.
	logic       plane_mem [PLANE_DEPTH];
	logic [1:0] row_mem   [MAX_DIM];

	logic       plane_rd_q;
	logic [1:0] row_rd_q;
	logic       plane_byp_q;
	logic       row_byp_q;
	logic       plane_byp_d_q;
	logic [1:0] row_byp_d_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			plane_mem[wr_plane_addr] <= wr_voxel;
		end
		if (rd_en) begin
			plane_rd_q <= plane_mem[rd_plane_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_row_addr] <= {wr_voxel, wr_back};
		end
		if (rd_en) begin
			row_rd_q <= row_mem[rd_row_addr];
		end
	end

	// A read that hits the entry being written in the same cycle takes the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_byp_q <= 1'b0;
			row_byp_q   <= 1'b0;
		end else if (rd_en) begin
			plane_byp_q <= wr_en && (wr_plane_addr == rd_plane_addr);
			row_byp_q   <= wr_en && (wr_row_addr == rd_row_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			plane_byp_d_q <= wr_voxel;
			row_byp_d_q   <= {wr_voxel, wr_back};
		end
	end

	always_comb begin
		nbr_raw.back = plane_byp_q ? plane_byp_d_q : plane_rd_q;
		nbr_raw.up   = row_byp_q ? row_byp_d_q[1] : row_rd_q[1];
		nbr_raw.diag = row_byp_q ? row_byp_d_q[0] : row_rd_q[0];
	end

endmodule

// ===== hw/rtl/vec_counter.sv =====
module vec_counter import vec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        rearm,
	input  item_flags_t flags,
	input  nbr_t        nbr,
	output totals_t     totals_next
);

	logic [7:0] window_q;
	logic [7:0] window;
	logic [3:0] prev;
	logic [3:0] d_vertex;
	logic [3:0] d_edge;
	logic [1:0] d_shared;
	logic [2:0] d_face;
	logic signed [5:0] d_euler;
	logic last_all;
	totals_t acc_q;

	assign last_all = flags.last_x & flags.last_y & flags.last_z;

	always_comb begin
		prev     = flags.x_nz ? window_q[7:4] : 4'd0;
		window   = {flags.voxel, nbr.back, nbr.up, nbr.diag, prev};
		d_vertex = vertex_inc(window, flags.last_x, flags.last_y, flags.last_z);
		d_edge   = edge_inc(window, flags.last_x, flags.last_y, flags.last_z);
		d_shared = flags.voxel ?
			({1'b0, window[3]} + {1'b0, window[5]} + {1'b0, window[6]}) : 2'd0;
		d_face   = flags.voxel ? (3'd6 - {1'b0, d_shared}) : 3'd0;
		// Per-voxel change of V - E + F - C, with F - C = 5 per cube minus shared faces.
		d_euler  = $signed({2'b00, d_vertex}) - $signed({2'b00, d_edge})
			+ (flags.voxel ? 6'sd5 : 6'sd0) - $signed({4'b0000, d_shared});
	end

	always_comb begin
		totals_next.euler  = acc_q.euler + {{(EULER_W-6){d_euler[5]}}, d_euler};
		totals_next.vertex = acc_q.vertex + VERTEX_W'(d_vertex);
		totals_next.edges  = acc_q.edges + EDGE_W'(d_edge);
		totals_next.face   = acc_q.face + FACE_W'(d_face);
		totals_next.cube   = acc_q.cube + CUBE_W'(flags.voxel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			acc_q    <= '0;
		end else if (rearm) begin
			window_q <= '0;
			acc_q    <= '0;
		end else if (step) begin
			window_q <= window;
			acc_q    <= last_all ? '0 : totals_next;
		end
	end

endmodule

// ===== hw/rtl/voxel_euler_characteristic_core.sv =====
// Streaming Euler characteristic of a 3-D binary voxel body. Voxels arrive as one
// occupancy bit per item in raster order (x fastest, then y, then z), and the core
// takes one item every clock cycle. After the last voxel of a volume it delivers one
// result item with vertices - edges + faces - cubes and the four counts, then starts
// over for the next volume without a pause. A result passes the history memory read,
// which fills the counting stage, and then the counting and result register. The
// input stalls only when the final voxel of a volume is waiting for the output
// register while the previous volume's result has not been taken; the voxels in
// between keep flowing while a result waits. Neighbors come from a plane memory of
// MAX_DIM*MAX_DIM bits and a row memory of MAX_DIM two-bit entries, each with one
// read and one write port per cycle. Every read whose value is used hits data written
// earlier in the same volume, so the memories need no clearing after reset. Sizes of
// 0 act as 1 and sizes above MAX_DIM act as MAX_DIM. Writing any size register restarts
// the volume scan and clears the counts; write sizes only while the core is idle.
module voxel_euler_characteristic_core import vec_pkg::*; #(
	parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       voxel_full,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [EULER_W-1:0]  euler_value,
	output logic [VERTEX_W-1:0]        vertex_total,
	output logic [EDGE_W-1:0]          edge_total,
	output logic [FACE_W-1:0]          face_total,
	output logic [CUBE_W-1:0]          cube_total
);

	localparam int PW = $clog2(MAX_DIM);
	localparam int PLANE_AW = $clog2(MAX_DIM * MAX_DIM);

	// Scan limits (effective size minus one) and scan position.
	logic [PW-1:0] lim_x_q, lim_y_q, lim_z_q;
	logic [PW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [PLANE_AW-1:0] plane_addr_q;
	logic [PW-1:0] cfg_lim;
	logic rearm;

	// Counting stage.
	logic                valid_s1;
	item_flags_t         flags_s1;
	logic [PW-1:0]       row_addr_s1;
	logic [PLANE_AW-1:0] plane_addr_s1;

	logic        accept;
	logic        step;
	logic        last_s1;
	logic        lx, ly, lz;
	nbr_t        nbr_raw;
	nbr_t        nbr;
	totals_t     totals_next;

	logic        out_valid_q;
	logic [EULER_W-1:0] euler_q;
	logic [VERTEX_W-1:0] vertex_q;
	logic [EDGE_W-1:0]  edge_q;
	logic [FACE_W-1:0]  face_q;
	logic [CUBE_W-1:0]  cube_q;

	// Clamp a written size into the supported range and keep it as a last index.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_lim = '0;
		end else if (32'(cfg_data) > MAX_DIM) begin
			cfg_lim = PW'(MAX_DIM - 1);
		end else begin
			cfg_lim = PW'(cfg_data - 9'd1);
		end
	end

	always_comb begin
		rearm = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index) inside
				REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: rearm = 1'b1;
				default:                            rearm = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x_q <= '0;
			lim_y_q <= '0;
			lim_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE_X: lim_x_q <= cfg_lim;
				REG_SIZE_Y: lim_y_q <= cfg_lim;
				REG_SIZE_Z: lim_z_q <= cfg_lim;
				default: ;
			endcase
		end
	end

	// The last voxel of a volume may only complete when the output register frees up;
	// any other voxel completes as soon as it reaches the counting stage.
	assign last_s1  = flags_s1.last_x & flags_s1.last_y & flags_s1.last_z;
	assign step     = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;
	assign accept   = in_valid && in_ready;

	assign lx = (pos_x_q == lim_x_q);
	assign ly = (pos_y_q == lim_y_q);
	assign lz = (pos_z_q == lim_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
			plane_addr_q <= '0;
		end else if (rearm) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
			plane_addr_q <= '0;
		end else if (accept) begin
			pos_x_q      <= lx ? '0 : pos_x_q + 1'b1;
			plane_addr_q <= (lx && ly) ? '0 : plane_addr_q + 1'b1;
			if (lx) begin
				pos_y_q <= ly ? '0 : pos_y_q + 1'b1;
				if (ly) begin
					pos_z_q <= lz ? '0 : pos_z_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1.voxel  <= voxel_full;
			flags_s1.last_x <= lx;
			flags_s1.last_y <= ly;
			flags_s1.last_z <= lz;
			flags_s1.x_nz   <= (pos_x_q != '0);
			flags_s1.y_nz   <= (pos_y_q != '0);
			flags_s1.z_nz   <= (pos_z_q != '0);
			row_addr_s1     <= pos_x_q;
			plane_addr_s1   <= plane_addr_q;
		end
	end

	// Neighbors outside the grid read as empty.
	always_comb begin
		nbr.up   = nbr_raw.up & flags_s1.y_nz;
		nbr.back = nbr_raw.back & flags_s1.z_nz;
		nbr.diag = nbr_raw.diag & flags_s1.y_nz & flags_s1.z_nz;
	end

	vec_history #(
		.MAX_DIM(MAX_DIM)
	) u_history (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (accept),
		.rd_row_addr   (pos_x_q),
		.rd_plane_addr (plane_addr_q),
		.wr_en         (step),
		.wr_row_addr   (row_addr_s1),
		.wr_plane_addr (plane_addr_s1),
		.wr_voxel      (flags_s1.voxel),
		.wr_back       (nbr.back),
		.nbr_raw       (nbr_raw)
	);

	vec_counter u_counter (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rearm       (rearm),
		.flags       (flags_s1),
		.nbr         (nbr),
		.totals_next (totals_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			euler_q  <= totals_next.euler;
			vertex_q <= totals_next.vertex;
			edge_q   <= totals_next.edges;
			face_q   <= totals_next.face;
			cube_q   <= totals_next.cube;
		end
	end

	assign out_valid    = out_valid_q;
	assign euler_value  = $signed(euler_q);
	assign vertex_total = vertex_q;
	assign edge_total   = edge_q;
	assign face_total   = face_q;
	assign cube_total   = cube_q;

	// The scan position never runs past the configured limits.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_x_q <= lim_x_q && pos_y_q <= lim_y_q && pos_z_q <= lim_z_q)
		else $error("scan position beyond the grid");

	// The plane address restarts together with the first voxel of every plane.
	a_plane_addr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_x_q == '0 && pos_y_q == '0) |-> plane_addr_q == '0)
		else $error("plane address out of step with the scan position");

	// A voxel in the counting stage is never overwritten before it completes.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |-> !accept)
		else $error("counting stage overwritten");

	// Completing the last voxel of a volume always presents a result next cycle.
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> out_valid_q)
		else $error("volume end without a result");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

// Testbench for the streaming voxel Euler characteristic core.
// A predictor in this module follows every accepted voxel. It keeps its own
// copy of the size registers, the history ring, the 2x2x2 window and the four
// running counts. At the end of each volume it queues the totals the core should
// deliver. A checker process compares every result item, field by field, with
// the oldest queued expectation. The tests run in turn from one initial block:
// directed cases first, then the size extremes, a long back-pressure stretch,
// and finally random volumes of small sizes.
module tb import vec_pkg::*; ();

	// Index past the end of the register list; the core must ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RING_WORDS = DEFAULT_MAX_DIM * (DEFAULT_MAX_DIM + 1);
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic signed [EULER_W-1:0] euler;
		logic [VERTEX_W-1:0]       vertex;
		logic [EDGE_W-1:0]         edges;
		logic [FACE_W-1:0]         face;
		logic [CUBE_W-1:0]         cube;
	} volume_totals_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      voxel_full;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [EULER_W-1:0] euler_value;
	logic [VERTEX_W-1:0]       vertex_total;
	logic [EDGE_W-1:0]         edge_total;
	logic [FACE_W-1:0]         face_total;
	logic [CUBE_W-1:0]         cube_total;

	voxel_euler_characteristic_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.voxel_full   (voxel_full),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.euler_value  (euler_value),
		.vertex_total (vertex_total),
		.edge_total   (edge_total),
		.face_total   (face_total),
		.cube_total   (cube_total)
	);

	// Predictor state: raw register values, scan position, window and counts.
	int unsigned size_reg [0:2];
	bit          history_ring [0:RING_WORDS-1];
	logic [7:0]  window_q;
	int unsigned scan_x, scan_y, scan_z;
	longint      vertex_tally, edge_tally, cube_tally, shared_count;

	volume_totals_t pending_totals[$];

	// Run statistics and error count.
	int mismatches;
	int results_checked;
	int voxels_sent;

	// Idling controls. Each side draws a random wait per item when enabled.
	bit tx_idle_on;
	bit rx_idle_on;
	int rx_wait;
	int hold_request;
	int hold_left;

	always #2 clk = ~clk;

	// Any run that takes far longer than the slowest legal schedule is hung.
	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic int unsigned span_of(input int unsigned raw);
		if (raw == 0)
			return 1;
		if (raw > DEFAULT_MAX_DIM)
			return DEFAULT_MAX_DIM;
		return raw;
	endfunction

	// True when any window voxel picked out by the three axis masks is occupied.
	// Window bit i holds offset (i[2], i[1], i[0]) along (x, y, z); offset 1 is
	// the current coordinate and offset 0 the one before it.
	function automatic bit window_hits(input logic [7:0] w, input logic [1:0] mx,
			input logic [1:0] my, input logic [1:0] mz);
		logic [7:0] pick;
		for (int i = 0; i < 8; i++)
			pick[i] = mx[(i >> 2) & 1] & my[(i >> 1) & 1] & mz[i & 1];
		return |(w & pick);
	endfunction

	function automatic void clear_volume();
		window_q = 8'd0;
		scan_x = 0;
		scan_y = 0;
		scan_z = 0;
		vertex_tally = 0;
		edge_tally = 0;
		cube_tally = 0;
		shared_count = 0;
	endfunction

	// Advances the predictor by one accepted voxel and queues the totals when
	// this voxel closes the volume.
	function automatic void count_voxel(input bit v);
		int unsigned sx, sy, sz, plane, ring, n;
		bit up, back, diag, lx, ly, lz;
		logic [7:0] w;
		logic [1:0] sel [0:1];
		longint faces, euler;
		volume_totals_t res;

		sx = span_of(size_reg[REG_SIZE_X]);
		sy = span_of(size_reg[REG_SIZE_Y]);
		sz = span_of(size_reg[REG_SIZE_Z]);
		plane = sx * sy;
		ring = plane + sx;
		n = (scan_z * sy + scan_y) * sx + scan_x;
		lx = (scan_x >= sx - 1);
		ly = (scan_y >= sy - 1);
		lz = (scan_z >= sz - 1);

		// Neighbors outside the grid read as empty. The diagonal one sits exactly
		// one ring length back, so it shares the slot the current voxel takes.
		up = (scan_y > 0) ? history_ring[(n - sx) % ring] : 1'b0;
		back = (scan_z > 0) ? history_ring[(n - plane) % ring] : 1'b0;
		diag = (scan_y > 0 && scan_z > 0) ? history_ring[n % ring] : 1'b0;
		history_ring[n % ring] = v;

		w = {v, back, up, diag, (scan_x > 0) ? window_q[7:4] : 4'd0};
		window_q = w;

		// Mask 2'b11 spans both offsets on an axis; 2'b10 is the far side, which
		// only exists once the scan reaches the last coordinate on that axis.
		sel[0] = 2'b11;
		sel[1] = 2'b10;
		for (int a = 0; a <= int'(lx); a++)
			for (int b = 0; b <= int'(ly); b++)
				for (int c = 0; c <= int'(lz); c++)
					vertex_tally += window_hits(w, sel[a], sel[b], sel[c]);
		for (int b = 0; b <= int'(ly); b++)
			for (int c = 0; c <= int'(lz); c++)
				edge_tally += window_hits(w, 2'b10, sel[b], sel[c]);
		for (int a = 0; a <= int'(lx); a++)
			for (int c = 0; c <= int'(lz); c++)
				edge_tally += window_hits(w, sel[a], 2'b10, sel[c]);
		for (int a = 0; a <= int'(lx); a++)
			for (int b = 0; b <= int'(ly); b++)
				edge_tally += window_hits(w, sel[a], sel[b], 2'b10);

		// Shared faces toward the previous voxel along x, y and z.
		if (v) begin
			cube_tally++;
			shared_count += w[3] + w[5] + w[6];
		end

		if (!lx) begin
			scan_x++;
			return;
		end
		scan_x = 0;
		if (!ly) begin
			scan_y++;
			return;
		end
		scan_y = 0;
		if (!lz) begin
			scan_z++;
			return;
		end

		faces = 6 * cube_tally - shared_count;
		euler = vertex_tally - edge_tally + faces - cube_tally;
		res.euler = euler[EULER_W-1:0];
		res.vertex = vertex_tally[VERTEX_W-1:0];
		res.edges = edge_tally[EDGE_W-1:0];
		res.face = faces[FACE_W-1:0];
		res.cube = cube_tally[CUBE_W-1:0];
		pending_totals.insert(pending_totals.size(), res);
		clear_volume();
	endfunction

	// Offers one voxel after a random gap and returns once it is accepted.
	task automatic offer_voxel(input bit v);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		voxel_full <= v;
		do
			@(posedge clk);
		while (!in_ready);
		count_voxel(v);
		voxels_sent++;
	endtask

	task automatic send_volume(input int count, input int density);
		for (int i = 0; i < count; i++)
			offer_voxel($urandom_range(0, 99) < density);
	endtask

	// Stops offering, waits for every expected result, then lets the pipeline
	// run empty in case a voxel that closes nothing is still being counted.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write. Only called while the core is idle.
	task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		if (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z) begin
			size_reg[idx] = value & 9'h1FF;
			clear_volume();
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_sizes(input int unsigned sx, input int unsigned sy,
			input int unsigned sz);
		write_size(REG_SIZE_X, sx);
		write_size(REG_SIZE_Y, sy);
		write_size(REG_SIZE_Z, sz);
	endtask

	task automatic flag_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("tb: %s mismatch on result %0d: expected %0d, got %0d",
					name, results_checked, want, got);
		end
	endtask

	// Receiver: ready drops for a long hold when a test asks for one, otherwise
	// for the wait drawn after each accepted result.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker, sampling at the rising edge.
	always @(posedge clk) begin : check_results
		volume_totals_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("tb: result item with nothing expected: euler %0d cubes %0d",
						euler_value, cube_total);
			end else begin
				want = pending_totals.pop_front();
				flag_field("euler_value", want.euler, euler_value);
				flag_field("vertex_total", want.vertex, vertex_total);
				flag_field("edge_total", want.edges, edge_total);
				flag_field("face_total", want.face, face_total);
				flag_field("cube_total", want.cube, cube_total);
			end
			results_checked++;
			rx_wait = rx_idle_on ? $urandom_range(0, 5) : 0;
		end
	end

	// Single voxels, a full cube, a size of zero, a scan cut short by a
	// register write, and a write to an index past the register list.
	task automatic test_directed_cases();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		// Reset sizes are 1x1x1: an empty voxel, then an occupied one.
		offer_voxel(1'b0);
		offer_voxel(1'b1);
		wait_for_drain();
		set_sizes(2, 2, 2);
		send_volume(8, 100);
		wait_for_drain();
		// Zero sizes act as one voxel per axis.
		set_sizes(0, 0, 0);
		offer_voxel(1'b1);
		wait_for_drain();
		// Half a volume, then rewriting a size throws the partial counts away.
		set_sizes(2, 2, 1);
		offer_voxel(1'b1);
		offer_voxel(1'b1);
		wait_for_drain();
		write_size(REG_SIZE_X, 2);
		offer_voxel(1'b1);
		offer_voxel(1'b0);
		offer_voxel(1'b0);
		offer_voxel(1'b1);
		wait_for_drain();
		// An unused index must neither change a size nor restart the scan.
		offer_voxel(1'b0);
		offer_voxel(1'b1);
		wait_for_drain();
		write_size(REG_UNUSED, 9'h1FF);
		offer_voxel(1'b1);
		offer_voxel(1'b1);
		wait_for_drain();
	endtask

	// A full-length row and a full-length stack of planes, with register
	// values above the limit and zero or one on the short axes.
	task automatic test_size_extremes();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		set_sizes(9'h1FF, 0, 1);
		send_volume(DEFAULT_MAX_DIM, 50);
		wait_for_drain();
		set_sizes(1, 0, 300);
		send_volume(DEFAULT_MAX_DIM, 30);
		wait_for_drain();
	endtask

	// The receiver holds off while two-voxel, then one-voxel volumes keep coming,
	// so result items back up and the core has to stall its input.
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		set_sizes(2, 1, 1);
		hold_request = 150;
		send_volume(16, 50);
		wait_for_drain();
		rx_idle_on = 1'b1;
		hold_request = 60;
		set_sizes(1, 1, 1);
		send_volume(10, 50);
		wait_for_drain();
	endtask

	// Mostly complete volumes of small random sizes and fill levels, with now
	// and then a scan abandoned halfway by a size write.
	task automatic test_random_volumes();
		int target_items;
		int start_items;
		int start_results;
		int sx, sy, sz, cells, reps;
		target_items = 180;
		start_items = voxels_sent;
		start_results = results_checked;
		while (voxels_sent - start_items < target_items ||
				results_checked - start_results < 4) begin
			sx = $urandom_range(1, 6);
			sy = $urandom_range(1, 4);
			sz = $urandom_range(1, 4);
			if ($urandom_range(0, 9) == 0)
				sx = $urandom_range(7, 20);
			cells = sx * sy * sz;
			wait_for_drain();
			// A size of one is sometimes written as zero.
			write_size(REG_SIZE_X, (sx == 1 && $urandom_range(0, 1)) ? 0 : sx);
			write_size(REG_SIZE_Y, (sy == 1 && $urandom_range(0, 1)) ? 0 : sy);
			write_size(REG_SIZE_Z, (sz == 1 && $urandom_range(0, 1)) ? 0 : sz);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			reps = $urandom_range(1, 3);
			for (int r = 0; r < reps; r++)
				send_volume(cells, $urandom_range(0, 4) * 25);
			if (cells > 1 && $urandom_range(0, 7) == 0)
				send_volume($urandom_range(1, cells - 1), $urandom_range(0, 100));
		end
		wait_for_drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SIZE_X;
		cfg_data = '0;
		in_valid = 1'b0;
		voxel_full = 1'b0;
		out_ready = 1'b0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_wait = 0;
		hold_request = 0;
		hold_left = 0;
		mismatches = 0;
		results_checked = 0;
		voxels_sent = 0;
		for (int i = 0; i < RING_WORDS; i++)
			history_ring[i] = 1'b0;
		for (int i = 0; i < 3; i++)
			size_reg[i] = 1;
		clear_volume();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_size_extremes();
		test_backpressure();
		test_random_volumes();

		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d voxels streamed, %0d volume results checked, %0d mismatches",
			voxels_sent, results_checked, mismatches);
		$display("tb: covered size registers from 0 to 511, full-length axes, rearm on write,");
		$display("tb: unused index and input stalls");
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/vec_pkg.sv
hw/rtl/vec_history.sv
hw/rtl/vec_counter.sv
hw/rtl/voxel_euler_characteristic_core.sv
verif/tb.sv
